/* sv/shsas_pkg.sv */
// Shared types, constants and the half-step table for the stepper sequencer.
// No dependencies; every other file but the checker refers to it by scoped names.
`timescale 1ns / 1ps

package shsas_pkg;

   localparam int ANGLE_W   = 20;
   localparam int PATTERN_W = 4;
   localparam int PERIOD_W  = 8;
   localparam int PHASE_W   = 3;
   localparam int CYCLES_W  = 16;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd2;
   localparam logic [CYCLES_W-1:0] CYCLES_MAX   = 16'hFFFF;
   localparam logic [PHASE_W-1:0]  LAST_PHASE   = 3'd7;

   // item kinds carried on tuser
   localparam logic MODE_TICK  = 1'b0;
   localparam logic MODE_START = 1'b1;

   // 360 deg * 16 = 5760 = 128 * 45
   localparam int ANGLE_UNITS_PER_REV = 5760;
   localparam int UNIT_SHIFT          = 7;
   localparam int UNIT_ODD            = 45;
   localparam int UNIT_ODD_LOG2       = 6;

   typedef struct packed {
      logic               valid;
      logic [ANGLE_W-1:0] mag;
   } cyc_launch_type;

   typedef struct packed {
      logic                valid;
      logic [CYCLES_W-1:0] count;
   } cyc_load_type;

   typedef struct packed {
      logic                 busy;
      logic [PATTERN_W-1:0] pattern;
   } result_type;

   // dir = 1 selects the reverse table
   function automatic logic [PATTERN_W-1:0] table_entry(input logic dir,
                                                        input logic [PHASE_W-1:0] idx);
      logic [PATTERN_W-1:0] fwd;
      logic [PATTERN_W-1:0] rev;
      case (idx)
         3'd0: begin fwd = 4'h8; rev = 4'h1; end
         3'd1: begin fwd = 4'hC; rev = 4'h3; end
         3'd2: begin fwd = 4'h4; rev = 4'h2; end
         3'd3: begin fwd = 4'h6; rev = 4'h6; end
         3'd4: begin fwd = 4'h2; rev = 4'h4; end
         3'd5: begin fwd = 4'h3; rev = 4'hC; end
         3'd6: begin fwd = 4'h1; rev = 4'h8; end
         default: begin fwd = 4'h9; rev = 4'h9; end
      endcase
      return dir ? rev : fwd;
   endfunction

endpackage

/* sv/shsas_cycle_calc.sv */
// Pipelined cycle-count unit: floor(mag * STEPS_PER_REV / 5760), saturated to 16 bits.
// Four stages: capture, scale, reciprocal multiply, shift and clamp. Uses shsas_pkg.
`timescale 1ns / 1ps

module shsas_cycle_calc #(
   parameter int STEPS_PER_REV = 512
) (
   input  logic                     clock,
   input  logic                     reset,
   input  shsas_pkg::cyc_launch_type launch,
   output shsas_pkg::cyc_load_type   load
);

   localparam int SPR_W       = $clog2(STEPS_PER_REV + 1);
   localparam int PROD_W      = shsas_pkg::ANGLE_W + SPR_W;
   localparam int SCALED_W    = PROD_W - shsas_pkg::UNIT_SHIFT;
   localparam int RECIP_SHIFT = SCALED_W + shsas_pkg::UNIT_ODD_LOG2;
   localparam longint unsigned RECIP =
      ((64'd1 << RECIP_SHIFT) + shsas_pkg::UNIT_ODD - 1) / shsas_pkg::UNIT_ODD;
   localparam int RECIP_W     = RECIP_SHIFT - 5;
   localparam int QPROD_W     = SCALED_W + RECIP_W;
   localparam int QUOT_W      = QPROD_W - RECIP_SHIFT;
   localparam int CMP_W       = (QUOT_W > shsas_pkg::CYCLES_W) ? QUOT_W : shsas_pkg::CYCLES_W;

   logic                            mag_valid_ff;
   logic [shsas_pkg::ANGLE_W-1:0]   mag_ff;
   logic                            prod_valid_ff;
   logic [PROD_W-1:0]               prod_ff;
   logic                            quot_valid_ff;
   logic [QPROD_W-1:0]              qprod_ff;
   logic                            load_valid_ff;
   logic [shsas_pkg::CYCLES_W-1:0]  count_ff;
   logic [SCALED_W-1:0]             scaled;
   logic [CMP_W-1:0]                quot_ext;
   logic [shsas_pkg::CYCLES_W-1:0]  count_in;

   // divide by 128 is a shift, then divide by 45 through the rounded-up reciprocal
   assign scaled   = prod_ff[PROD_W-1:shsas_pkg::UNIT_SHIFT];
   assign quot_ext = CMP_W'(qprod_ff[QPROD_W-1:RECIP_SHIFT]);

   always_comb begin
      if (quot_ext > CMP_W'(shsas_pkg::CYCLES_MAX)) begin
         count_in = shsas_pkg::CYCLES_MAX;
      end else begin
         count_in = quot_ext[shsas_pkg::CYCLES_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_valid_ff  <= 1'b0;
         prod_valid_ff <= 1'b0;
         quot_valid_ff <= 1'b0;
         load_valid_ff <= 1'b0;
      end else begin
         mag_valid_ff  <= launch.valid;
         prod_valid_ff <= mag_valid_ff;
         quot_valid_ff <= prod_valid_ff;
         load_valid_ff <= quot_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff   <= launch.mag;
      prod_ff  <= PROD_W'(mag_ff) * PROD_W'(STEPS_PER_REV);
      qprod_ff <= QPROD_W'(scaled) * QPROD_W'(RECIP_W'(RECIP));
      count_ff <= count_in;
   end

   assign load.valid = load_valid_ff;
   assign load.count = count_ff;

endmodule

/* sv/shsas_seq_core.sv */
// Sequencer state: phase, hold counter, direction, remaining cycles, coil pattern.
// Computes the post-item result for each processed item. Uses shsas_pkg.
`timescale 1ns / 1ps

module shsas_seq_core #(
   parameter int STEPS_PER_REV = 512
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [shsas_pkg::PERIOD_W-1:0]    csr_wdata,
   input  logic                              fire,
   input  logic                              mode,
   input  logic [shsas_pkg::ANGLE_W-1:0]     angle,
   input  shsas_pkg::cyc_load_type           cyc_load,
   output shsas_pkg::cyc_launch_type         cyc_launch,
   output shsas_pkg::result_type             result
);

   // smallest magnitude that gives at least one cycle
   localparam int MIN_MAG = (shsas_pkg::ANGLE_UNITS_PER_REV + STEPS_PER_REV - 1) / STEPS_PER_REV;

   logic [shsas_pkg::PERIOD_W-1:0]  period_ff;
   logic [shsas_pkg::PATTERN_W-1:0] pattern_ff, pattern_in;
   logic [shsas_pkg::PHASE_W-1:0]   phase_ff, phase_in;
   logic [shsas_pkg::CYCLES_W-1:0]  cycles_ff, cycles_in;
   logic [shsas_pkg::PERIOD_W-1:0]  hold_ff, hold_in;
   logic                            dir_ff, dir_in;
   logic                            moving_ff, moving_in;
   logic [shsas_pkg::PERIOD_W-1:0]  period_ticks;
   logic [shsas_pkg::CYCLES_W-1:0]  cycles_dec;
   logic                            neg;
   logic [shsas_pkg::ANGLE_W-1:0]   mag;
   logic                            start_go;

   assign period_ticks = (period_ff == '0) ? shsas_pkg::PERIOD_W'(1) : period_ff;
   assign neg          = angle[shsas_pkg::ANGLE_W-1];
   // 20-bit negate; the most negative angle maps onto its own magnitude
   assign mag          = neg ? (~angle + shsas_pkg::ANGLE_W'(1)) : angle;
   assign start_go     = fire && (mode == shsas_pkg::MODE_START) && !moving_ff &&
                         (mag >= shsas_pkg::ANGLE_W'(MIN_MAG));
   assign cycles_dec   = (cycles_ff != '0) ? cycles_ff - shsas_pkg::CYCLES_W'(1) : cycles_ff;

   always_comb begin
      pattern_in = pattern_ff;
      phase_in   = phase_ff;
      cycles_in  = cyc_load.valid ? cyc_load.count : cycles_ff;
      hold_in    = hold_ff;
      dir_in     = dir_ff;
      moving_in  = moving_ff;
      if (start_go) begin
         dir_in     = !neg;
         phase_in   = '0;
         pattern_in = shsas_pkg::table_entry(!neg, '0);
         hold_in    = period_ticks;
         moving_in  = 1'b1;
      end else if (fire && (mode == shsas_pkg::MODE_TICK) && moving_ff) begin
         if (hold_ff > shsas_pkg::PERIOD_W'(1)) begin
            hold_in = hold_ff - shsas_pkg::PERIOD_W'(1);
         end else if (phase_ff == shsas_pkg::LAST_PHASE) begin
            // end of an eight-phase cycle; count was loaded long before this point
            cycles_in = cycles_dec;
            if (cycles_dec == '0) begin
               hold_in   = '0;
               moving_in = 1'b0;
            end else begin
               phase_in   = '0;
               pattern_in = shsas_pkg::table_entry(dir_ff, '0);
               hold_in    = period_ticks;
            end
         end else begin
            phase_in   = phase_ff + shsas_pkg::PHASE_W'(1);
            pattern_in = shsas_pkg::table_entry(dir_ff, phase_ff + shsas_pkg::PHASE_W'(1));
            hold_in    = period_ticks;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= shsas_pkg::PERIOD_RESET;
         pattern_ff <= '0;
         phase_ff   <= '0;
         cycles_ff  <= '0;
         hold_ff    <= '0;
         dir_ff     <= 1'b0;
         moving_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            period_ff <= csr_wdata;
         end
         pattern_ff <= pattern_in;
         phase_ff   <= phase_in;
         cycles_ff  <= cycles_in;
         hold_ff    <= hold_in;
         dir_ff     <= dir_in;
         moving_ff  <= moving_in;
      end
   end

   assign cyc_launch.valid = start_go;
   assign cyc_launch.mag   = mag;
   assign result.busy      = moving_in;
   assign result.pattern   = pattern_in;

endmodule

/* sv/stepper_half_step_angle_sequencer.sv */
// Half-step sequencer for a four-coil unipolar stepper. Every item, tick or start,
// is taken into an input register and yields one result in the output register;
// the block sustains one item per clock while the receiver takes results, and
// while a result waits the input register still takes one more item before the
// input stalls. A start's cycle count goes through a four-stage multiply pipeline
// and is loaded before the eight ticks that the first cycle takes at the least.
// No clearing pass after reset. Uses shsas_pkg, shsas_seq_core, shsas_cycle_calc.
`timescale 1ns / 1ps

module stepper_half_step_angle_sequencer #(
   parameter int STEPS_PER_REV = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata,   // step_period
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [19:0] angle, [23:20] zero
   input  logic        req_tuser,   // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [3:0] coil_pattern, [4] busy_res, [7:5] zero
);

   logic                             in_valid_ff;
   logic                             in_mode_ff;
   logic [shsas_pkg::ANGLE_W-1:0]    in_angle_ff;
   logic                             rsp_valid_ff;
   shsas_pkg::result_type            rsp_data_ff;
   logic                             out_free;
   logic                             fire;
   shsas_pkg::result_type            result;
   shsas_pkg::cyc_launch_type        cyc_launch;
   shsas_pkg::cyc_load_type          cyc_load;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (out_free) begin
            rsp_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_mode_ff  <= req_tuser;
         in_angle_ff <= req_tdata[shsas_pkg::ANGLE_W-1:0];
      end
      if (fire) begin
         rsp_data_ff <= result;
      end
   end

   shsas_seq_core #(
      .STEPS_PER_REV (STEPS_PER_REV)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .fire       (fire),
      .mode       (in_mode_ff),
      .angle      (in_angle_ff),
      .cyc_load   (cyc_load),
      .cyc_launch (cyc_launch),
      .result     (result)
   );

   shsas_cycle_calc #(
      .STEPS_PER_REV (STEPS_PER_REV)
   ) u_calc (
      .clock  (clock),
      .reset  (reset),
      .launch (cyc_launch),
      .load   (cyc_load)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_data_ff.busy, rsp_data_ff.pattern};

endmodule

/* sv/shsas_checker.sv */
// Port-level checks for the stepper sequencer, bound to the top level.
// Sees only the top-level ports; no package dependency.
`timescale 1ns / 1ps

module shsas_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // a result held back by the sink stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   // with the output register empty the input side must be open
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   // a move in progress always drives some coil
   a_busy_energized: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4] |-> rsp_tdata[3:0] != 4'h0)
      else $error("busy with all coils off");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind stepper_half_step_angle_sequencer shsas_checker u_shsas_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

/* tb/stepper_half_step_angle_sequencer_test.sv */
// Self-checking test of the half-step stepper sequencer: tick and start items go in,
// one coil/busy result per item is predicted and compared. Needs shsas_pkg and the DUT.
`timescale 1ns / 1ps

module stepper_half_step_angle_sequencer_test;

   localparam int STEPS_PER_REV = 512;
   // half-step patterns, phase 0 in the low nibble
   localparam logic [31:0] FWD_SEQ = 32'h9132_64C8;
   localparam logic [31:0] REV_SEQ = 32'h98C4_6231;

   // Tracks the sequencer state and holds the coil results still owed by the DUT.
   class coil_tracker;
      logic [7:0]  step_period;
      logic [3:0]  coils;
      logic [2:0]  phase;
      logic [15:0] cycles_left;
      logic [7:0]  hold;
      logic        reverse;
      logic        moving;
      shsas_pkg::result_type owed_q[$];
      int          errors;

      function void clear();
         step_period = shsas_pkg::PERIOD_RESET;
         coils       = '0;
         phase       = '0;
         cycles_left = '0;
         hold        = '0;
         reverse     = 1'b0;
         moving      = 1'b0;
         owed_q.delete();
         errors      = 0;
      endfunction

      function logic [7:0] hold_ticks();
         return (step_period == 8'd0) ? 8'd1 : step_period;
      endfunction

      function logic [3:0] coil_word(logic rev, logic [2:0] idx);
         return rev ? REV_SEQ[{idx, 2'b00} +: 4] : FWD_SEQ[{idx, 2'b00} +: 4];
      endfunction

      function void launch(logic [19:0] angle);
         int     mag;
         longint cyc;
         // 0x100000 - 0x80000 gives 0x80000, so the most negative angle needs no special path
         mag = angle[19] ? (32'h10_0000 - int'(angle)) : int'(angle);
         cyc = (longint'(mag) * STEPS_PER_REV) / shsas_pkg::ANGLE_UNITS_PER_REV;
         if (cyc == 0)
            return;
         if (cyc > 65535)
            cyc = 65535;
         cycles_left = cyc[15:0];
         reverse     = !angle[19];
         phase       = '0;
         coils       = coil_word(reverse, 3'd0);
         hold        = hold_ticks();
         moving      = 1'b1;
      endfunction

      function void advance();
         if (hold > 8'd1) begin
            hold--;
            return;
         end
         if (phase == shsas_pkg::LAST_PHASE) begin
            if (cycles_left > 0)
               cycles_left--;
            if (cycles_left == 0) begin
               hold   = '0;
               moving = 1'b0;
               return;
            end
            phase = '0;
         end else begin
            phase++;
         end
         coils = coil_word(reverse, phase);
         hold  = hold_ticks();
      endfunction

      function void accept_item(logic mode, logic [19:0] angle);
         shsas_pkg::result_type r;
         if (mode == shsas_pkg::MODE_START) begin
            if (!moving)
               launch(angle);
         end else if (moving) begin
            advance();
         end
         r.pattern = coils;
         r.busy    = moving;
         owed_q.push_back(r);
      endfunction

      function void check_coils(logic [7:0] word);
         shsas_pkg::result_type want;
         if (owed_q.size() == 0) begin
            $error("unexpected result item, tdata %h", word);
            errors++;
            return;
         end
         want = owed_q.pop_front();
         if (word[3:0] !== want.pattern) begin
            $error("coil_pattern: expected %h, actual %h", want.pattern, word[3:0]);
            errors++;
         end
         if (word[4] !== want.busy) begin
            $error("busy_res: expected %b, actual %b", want.busy, word[4]);
            errors++;
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_we     = 1'b0;
   logic [7:0]  csr_wdata  = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // [19:0] angle, [23:20] zero
   logic        req_tuser  = 1'b0; // mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // [3:0] coil_pattern, [4] busy_res, [7:5] zero

   coil_tracker motor = new();

   int stall_left = 0;
   int style_left = 0;
   int rsp_style  = 0;
   int rsp_cycle  = 0;

   always #2 clock = ~clock;

   stepper_half_step_angle_sequencer #(
      .STEPS_PER_REV(STEPS_PER_REV)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Receiver: switches between always ready, coin flip and mostly stalled; now and
   // then a long hold-off so the DUT backs up into its input.
   always @(posedge clock) begin
      rsp_cycle++;
      if (rsp_cycle % 2500 == 700)
         stall_left = 400;
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (style_left == 0) begin
            rsp_style  = $urandom_range(0, 2);
            style_left = $urandom_range(20, 200);
         end else begin
            style_left--;
         end
         case (rsp_style)
            0: begin
               rsp_tready <= 1'b1;
            end
            1: begin
               rsp_tready <= 1'($urandom_range(0, 1));
            end
            default: begin
               rsp_tready <= ($urandom_range(0, 7) == 0);
            end
         endcase
      end
   end

   // handshake signals are stable at the falling edge; a hit here is taken at the next rise
   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         motor.check_coils(rsp_tdata);
   end

   // call right after a rising edge; returns at the edge that took the item
   task automatic send_item(input logic mode, input logic [19:0] angle);
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {4'b0000, angle};
      @(negedge clock);
      while (!req_tready)
         @(negedge clock);
      @(posedge clock);
      motor.accept_item(mode, angle);
   endtask

   task automatic send_tick();
      send_item(shsas_pkg::MODE_TICK, 20'($urandom));
   endtask

   task automatic hold_off(input int cycles);
      if (cycles > 0) begin
         req_tvalid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (motor.owed_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_period(input logic [7:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      motor.step_period = value;
   endtask

   // Idle: mostly short moves the run can tick through; busy: mostly ticks, and
   // starts with any angle, which the DUT has to ignore.
   function automatic void pick_item(output logic mode, output logic [19:0] angle);
      int mag;
      int top;
      angle = 20'($urandom);
      if (motor.moving) begin
         mode = ($urandom_range(0, 99) < 88) ? shsas_pkg::MODE_TICK : shsas_pkg::MODE_START;
      end else begin
         mode = ($urandom_range(0, 99) < 40) ? shsas_pkg::MODE_TICK : shsas_pkg::MODE_START;
         if (mode == shsas_pkg::MODE_START) begin
            top   = (motor.step_period > 8'd8) ? 22 : 100;
            mag   = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 11)
                                                : $urandom_range(12, top);
            angle = $urandom_range(0, 1) ? 20'(-mag) : 20'(mag);
         end
      end
   endfunction

   task automatic run_random(input int count);
      int          sent;
      int          burst;
      logic        mode;
      logic [19:0] angle;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 40);
         repeat (burst) begin
            pick_item(mode, angle);
            send_item(mode, angle);
            sent++;
         end
         hold_off(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6));
      end
   endtask

   initial begin
      int periods[7];
      periods = '{8'd0, 8'd255, 8'd1, 8'd3, 8'd2, 8'd9, 8'd1};
      periods[5] = $urandom_range(4, 16);
      motor.clear();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: reset period, idle tick, zero-count starts, one reverse cycle
      // with a start while busy, then a forward start
      send_tick();
      send_item(shsas_pkg::MODE_START, 20'd0);
      send_item(shsas_pkg::MODE_START, 20'd11);
      send_item(shsas_pkg::MODE_START, -20'sd11);
      send_item(shsas_pkg::MODE_START, 20'd12);
      repeat (3) send_tick();
      send_item(shsas_pkg::MODE_START, -20'sd100);
      repeat (13) send_tick();
      send_item(shsas_pkg::MODE_START, -20'sd12);

      // period changes also land mid-move; they apply at the next phase change
      foreach (periods[i]) begin
         drain();
         write_period(8'(periods[i]));
         run_random(100);
         drain();
         run_random(90);
      end

      // last period is 1: finish the move, then the most negative angle
      while (motor.moving)
         send_tick();
      send_item(shsas_pkg::MODE_START, 20'h8_0000);
      repeat (20) send_tick();
      send_item(shsas_pkg::MODE_START, 20'h7_FFFF);
      send_tick();

      drain();
      repeat (8) @(posedge clock);
      if (motor.errors == 0) begin
         $display("stepper_half_step_angle_sequencer_test: done, clean");
      end else begin
         $display("stepper_half_step_angle_sequencer_test: done, errors");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("stepper_half_step_angle_sequencer_test: done, errors");
      $finish;
   end

endmodule

/* files.f */
sv/shsas_pkg.sv
sv/shsas_cycle_calc.sv
sv/shsas_seq_core.sv
sv/stepper_half_step_angle_sequencer.sv
sv/shsas_checker.sv
tb/stepper_half_step_angle_sequencer_test.sv
